@@ rtl/wbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// Signature layout, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int BYTE_W       = 8;
   localparam int SIG_BYTES    = 16;                  // bytes held in the pattern registers
   localparam int SIG_IDX_W    = $clog2(SIG_BYTES);
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int LEN_CFG_W    = 5;
   localparam int CARE_W       = SIG_BYTES;
   localparam int OFFSET_OUT_W = 32;

   localparam int DEF_MAX_PATTERN_BYTES = 16;
   localparam int DEF_OFFSET_BITS       = 32;

   localparam logic [CSR_DATA_W-1:0] RST_PATTERN = '0;
   localparam logic [CARE_W-1:0]     RST_CARE    = '1;
   localparam logic [LEN_CFG_W-1:0]  RST_LENGTH  = LEN_CFG_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_index_type;

   // signature bytes and care bits as seen by every cell
   typedef struct packed {
      logic [SIG_BYTES-1:0][BYTE_W-1:0] sig;
      logic [SIG_BYTES-1:0]             care;
   } sig_cfg_type;

endpackage

@@ rtl/wbps_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell: one window cell
// Holds one byte of the window, passes it on each beat and compares the byte
// it takes in against the signature byte lined up with its place.
// ----------------------------------------------------------------------------
module wbps_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 5
) (
   input  logic                         clock,
   input  logic                         shift_en,
   input  logic [wbps_pkg::BYTE_W-1:0]  shift_byte,
   input  logic [LEN_W-1:0]             len_eff,
   input  wbps_pkg::sig_cfg_type        sig_cfg,
   output logic [wbps_pkg::BYTE_W-1:0]  byte_out,
   output logic                         hit
);

   localparam int KW = LEN_W + wbps_pkg::SIG_IDX_W;

   logic [wbps_pkg::BYTE_W-1:0]    byte_ff;
   logic [wbps_pkg::BYTE_W-1:0]    byte_in;
   logic [KW-1:0]                  k_wide;
   logic [wbps_pkg::SIG_IDX_W-1:0] k_sel;
   logic                           active;
   logic                           in_sig;

   // cell INDEX compares the byte INDEX places back, i.e. signature byte len-1-INDEX
   assign active = len_eff > LEN_W'(INDEX);
   assign k_wide = KW'(len_eff) - KW'(INDEX) - KW'(1);
   assign in_sig = k_wide < KW'(wbps_pkg::SIG_BYTES);
   assign k_sel  = k_wide[wbps_pkg::SIG_IDX_W-1:0];

   assign hit = !active || !in_sig || !sig_cfg.care[k_sel] ||
                (shift_byte == sig_cfg.sig[k_sel]);

   assign byte_in  = shift_en ? shift_byte : byte_ff;
   assign byte_out = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

@@ rtl/wildcard_byte_pattern_search.sv @@
`timescale 1ns / 1ps
// A result beat is registered in rsp_, or in the spare register while rsp_ stalls.
// Throughput: one byte per cycle while req_stall is low; cells compare while shifting.
// req_stall is registered: it is high only while a second result beat waits in the
// spare register behind a stalled rsp_ beat.
// Reset (synchronous, active high) clears position, match flag, output valids
// and loads register defaults; the window bytes are not cleared.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search: wildcard signature search over a byte stream
// A row of cells forms the byte window. Every beat shifts one byte in, each
// cell checks its byte against the signature byte aligned to it, and the
// AND of all cells with the position check gives a match at this start.
// One result per region: first match, or not found at the last byte.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
   parameter int OFFSET_BITS       = wbps_pkg::DEF_OFFSET_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte stream
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wbps_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_last_byte,
   // result
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [wbps_pkg::OFFSET_OUT_W-1:0]   rsp_match_offset,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CMP_W = LEN_W + wbps_pkg::LEN_CFG_W;
   localparam int WIDE_OFF_W = OFFSET_BITS + wbps_pkg::OFFSET_OUT_W;

   // ---------------- configuration registers ----------------
   logic [wbps_pkg::CSR_DATA_W-1:0] pat_low_ff,  pat_low_in;
   logic [wbps_pkg::CSR_DATA_W-1:0] pat_high_ff, pat_high_in;
   logic [wbps_pkg::CARE_W-1:0]     care_ff,     care_in;
   logic [wbps_pkg::LEN_CFG_W-1:0]  len_cfg_ff,  len_cfg_in;
   wbps_pkg::csr_index_type         csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = wbps_pkg::csr_index_type'(csr_index);

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      care_in     = care_ff;
      len_cfg_in  = len_cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_sel)
            wbps_pkg::CSR_PATTERN_LOW:  pat_low_in  = csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH: pat_high_in = csr_wdata;
            wbps_pkg::CSR_CARE_MASK:    care_in     = csr_wdata[wbps_pkg::CARE_W-1:0];
            wbps_pkg::CSR_PATTERN_LEN:  len_cfg_in  = csr_wdata[wbps_pkg::LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= wbps_pkg::RST_PATTERN;
         pat_high_ff <= wbps_pkg::RST_PATTERN;
         care_ff     <= wbps_pkg::RST_CARE;
         len_cfg_ff  <= wbps_pkg::RST_LENGTH;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         care_ff     <= care_in;
         len_cfg_ff  <= len_cfg_in;
      end
   end

   // signature as seen by the cells: low register holds bytes 0..7
   wbps_pkg::sig_cfg_type sig_cfg;
   assign sig_cfg.sig  = {pat_high_ff, pat_low_ff};
   assign sig_cfg.care = care_ff;

   // effective length: zero reads as one, clamp to the window depth
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] len_m1;
   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (CMP_W'(len_cfg_ff) > CMP_W'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = LEN_W'(len_cfg_ff);
      end
   end
   assign len_m1 = len_eff - LEN_W'(1);

   // ---------------- handshake ----------------
   logic req_accept;
   logic rsp_take;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [wbps_pkg::OFFSET_OUT_W-1:0] rsp_offset_ff, rsp_offset_in;
   // spare beat behind a stalled output register
   logic skid_valid_ff, skid_valid_in;
   logic skid_found_ff, skid_found_in;
   logic [wbps_pkg::OFFSET_OUT_W-1:0] skid_offset_ff, skid_offset_in;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   // ---------------- window cells ----------------
   logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] cell_byte;
   logic [MAX_PATTERN_BYTES-1:0]                       cell_hit;

   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [wbps_pkg::BYTE_W-1:0] feed;
      if (j == 0) begin : g_head
         assign feed = req_data_byte;
      end else begin : g_link
         assign feed = cell_byte[j-1];
      end
      wbps_cell #(
         .INDEX (j),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .shift_en   (req_accept),
         .shift_byte (feed),
         .len_eff    (len_eff),
         .sig_cfg    (sig_cfg),
         .byte_out   (cell_byte[j]),
         .hit        (cell_hit[j])
      );
   end

   // ---------------- region state ----------------
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   reported_ff, reported_in;
   logic                   pos_ok;
   logic                   match_now;
   logic [OFFSET_BITS-1:0] start_pos;
   logic [WIDE_OFF_W-1:0]  start_wide;

   // full signature fits in the bytes seen so far
   assign pos_ok     = pos_ff >= OFFSET_BITS'(len_m1);
   assign match_now  = !reported_ff && pos_ok && (&cell_hit);
   assign start_pos  = pos_ff - OFFSET_BITS'(len_m1);
   assign start_wide = WIDE_OFF_W'(start_pos);

   always_comb begin
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            pos_in      = '0;
            reported_in = 1'b0;
         end else begin
            // saturate at all ones
            if (pos_ff != '1) begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
            reported_in = reported_ff || match_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         reported_ff <= reported_in;
      end
   end

   // ---------------- result registers ----------------
   logic                              res_new;
   logic                              res_found;
   logic [wbps_pkg::OFFSET_OUT_W-1:0] res_offset;

   always_comb begin
      res_new    = 1'b0;
      res_found  = 1'b0;
      res_offset = '0;
      if (req_accept) begin
         if (match_now) begin
            res_new    = 1'b1;
            res_found  = 1'b1;
            res_offset = start_wide[wbps_pkg::OFFSET_OUT_W-1:0];
         end else if (req_last_byte && !reported_ff) begin
            res_new    = 1'b1;
         end
      end
   end

   // output register refills from the spare beat first, else from the new one;
   // a new beat behind a stalled output goes to the spare register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_offset_in  = rsp_offset_ff;
      skid_valid_in  = skid_valid_ff;
      skid_found_in  = skid_found_ff;
      skid_offset_in = skid_offset_ff;
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = skid_found_ff;
            rsp_offset_in = skid_offset_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = res_new;
            if (res_new) begin
               rsp_found_in  = res_found;
               rsp_offset_in = res_offset;
            end
         end
      end else if (res_new) begin
         skid_valid_in  = 1'b1;
         skid_found_in  = res_found;
         skid_offset_in = res_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_found_ff   <= rsp_found_in;
      rsp_offset_ff  <= rsp_offset_in;
      skid_found_ff  <= skid_found_in;
      skid_offset_ff <= skid_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // ---------------- checks ----------------
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("not-found beat carries a nonzero offset");

   a_match_sticks: assert property (@(posedge clock) disable iff (reset)
      req_accept && match_now && !req_last_byte |=> reported_ff)
      else $error("match flag not set after a match");

   a_region_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> pos_ff == '0 && !reported_ff)
      else $error("region state not cleared after the last byte");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !match_now)
      else $error("second match in one region");

   a_spare_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("spare beat held while the output register is empty");

endmodule

@@ tb/tb_wildcard_byte_pattern_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_search: self-checking bench for the signature search
// Streams regions of bytes under several signature settings. A scoreboard
// predicts the first match or the not-found beat of every region and checks
// each result beat in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_search;

   localparam int CLK_HALF    = 4;        // 8 ns period
   localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
   localparam int BATCHES     = 9;
   localparam int BATCH_BEATS = 36;

   // one expected or observed result beat
   typedef struct {
      logic                              found;
      logic [wbps_pkg::OFFSET_OUT_W-1:0] offset;
   } search_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: private copy of the registers and the byte window; every
   // accepted byte beat may push one expected result, every result beat
   // pops the oldest one.
   // -------------------------------------------------------------------------
   class match_scoreboard;
      logic [wbps_pkg::CSR_DATA_W-1:0]      pat_low;
      logic [wbps_pkg::CSR_DATA_W-1:0]      pat_high;
      logic [wbps_pkg::CARE_W-1:0]          care;
      logic [wbps_pkg::LEN_CFG_W-1:0]       len_cfg;
      logic [wbps_pkg::BYTE_W-1:0]          window [wbps_pkg::SIG_BYTES];
      logic [wbps_pkg::DEF_OFFSET_BITS-1:0] position;
      bit                                   reported;
      search_result_type                    expected_q [$];
      int                                   errors;

      function new();
         pat_low  = wbps_pkg::RST_PATTERN;
         pat_high = wbps_pkg::RST_PATTERN;
         care     = wbps_pkg::RST_CARE;
         len_cfg  = wbps_pkg::RST_LENGTH;
         errors   = 0;
         clear_region();
      endfunction

      function void clear_region();
         foreach (window[i]) window[i] = '0;
         position = '0;
         reported = 1'b0;
      endfunction

      function void write_reg(wbps_pkg::csr_index_type idx,
                              logic [wbps_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            wbps_pkg::CSR_PATTERN_LOW:  pat_low  = value;
            wbps_pkg::CSR_PATTERN_HIGH: pat_high = value;
            wbps_pkg::CSR_CARE_MASK:    care     = value[wbps_pkg::CARE_W-1:0];
            wbps_pkg::CSR_PATTERN_LEN:  len_cfg  = value[wbps_pkg::LEN_CFG_W-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, oversize clamps to the window depth
      function int unsigned eff_len();
         if (len_cfg == 0) return 1;
         if (len_cfg > wbps_pkg::DEF_MAX_PATTERN_BYTES) return wbps_pkg::DEF_MAX_PATTERN_BYTES;
         return len_cfg;
      endfunction

      function logic [wbps_pkg::BYTE_W-1:0] sig_byte(int unsigned i);
         logic [2*wbps_pkg::CSR_DATA_W-1:0] both;
         both = {pat_high, pat_low};
         return both[wbps_pkg::BYTE_W*i +: wbps_pkg::BYTE_W];
      endfunction

      function void note_byte(logic [wbps_pkg::BYTE_W-1:0] d, logic last);
         int unsigned len;
         logic [wbps_pkg::DEF_OFFSET_BITS-1:0] here;
         bit hit;
         search_result_type r;
         len  = eff_len();
         here = position;
         for (int i = wbps_pkg::SIG_BYTES - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = d;
         if (position != '1) position++;
         if (!reported && here >= len - 1) begin
            hit = 1'b1;
            for (int unsigned i = 0; i < len; i++)
               if (care[i] && window[len-1-i] != sig_byte(i)) hit = 1'b0;
            if (hit) begin
               r.found  = 1'b1;
               r.offset = wbps_pkg::OFFSET_OUT_W'(here - (len - 1));
               expected_q.push_back(r);
               reported = 1'b1;
            end
         end
         if (last) begin
            if (!reported) begin
               r.found  = 1'b0;
               r.offset = '0;
               expected_q.push_back(r);
            end
            clear_region();
         end
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic found, logic [wbps_pkg::OFFSET_OUT_W-1:0] offset);
         search_result_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result found=%b offset=%0d", found, offset));
         end else begin
            e = expected_q.pop_front();
            if (found !== e.found)
               report($sformatf("found %b, expected %b", found, e.found));
            if (offset !== e.offset)
               report($sformatf("match_offset %0d, expected %0d", offset, e.offset));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [wbps_pkg::BYTE_W-1:0]       req_data_byte = '0;
   logic                              req_last_byte = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_found;
   logic [wbps_pkg::OFFSET_OUT_W-1:0] rsp_match_offset;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [wbps_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [wbps_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   wildcard_byte_pattern_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   match_scoreboard sb;
   int send_idle_pct = 28;    // chance per cycle that the sender holds back
   int recv_idle_pct = 69;    // chance per cycle that the receiver stalls
   int hold_left     = 0;     // long receiver hold-off, counted down here
   int sent_count    = 0;     // accepted byte beats
   int cycle_count   = 0;

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // receiver stall, driven at the falling edge
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result beats are taken at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_found, rsp_match_offset);
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // one byte beat; valid stays high after acceptance so back-to-back beats
   // never drop it within a step
   task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] d, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(d, last);
      sent_count++;
   endtask

   task automatic send_region(input logic [wbps_pkg::BYTE_W-1:0] bytes_q [$]);
      foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   // stop sending and let every expected beat come back; the extra cycles
   // cover a beat still in flight that gives no result
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input wbps_pkg::csr_index_type idx,
                            input logic [wbps_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, value);
   endtask

   task automatic set_search(input logic [wbps_pkg::CSR_DATA_W-1:0] low,
                             input logic [wbps_pkg::CSR_DATA_W-1:0] high,
                             input logic [wbps_pkg::CARE_W-1:0] care,
                             input logic [wbps_pkg::LEN_CFG_W-1:0] len);
      write_reg(wbps_pkg::CSR_PATTERN_LOW, low);
      write_reg(wbps_pkg::CSR_PATTERN_HIGH, high);
      write_reg(wbps_pkg::CSR_CARE_MASK, wbps_pkg::CSR_DATA_W'(care));
      write_reg(wbps_pkg::CSR_PATTERN_LEN, wbps_pkg::CSR_DATA_W'(len));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A region of random bytes, biased toward signature bytes. Most regions
   // carry a planted signature; some carry one cut off by the region end,
   // a few are pure noise.
   task automatic send_random_region();
      int unsigned len;
      int n;
      int s;
      int mode;
      logic [wbps_pkg::BYTE_W-1:0] bytes_q [$];
      len = sb.eff_len();
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, len + 10);
      for (int k = 0; k < n; k++)
         bytes_q.push_back(($urandom_range(2) == 0)
                           ? sb.sig_byte($urandom_range(wbps_pkg::SIG_BYTES - 1))
                           : wbps_pkg::BYTE_W'($urandom));
      mode = $urandom_range(9);
      if (mode < 7 && n >= int'(len))
         s = $urandom_range(n - len);
      else if (mode < 9)
         s = n - int'(len) + 1 + $urandom_range(len - 1);   // runs past the end
      else
         s = -1;
      if (s >= 0) begin
         for (int unsigned i = 0; i < len; i++)
            if (sb.care[i] && s + int'(i) < n) bytes_q[s + i] = sb.sig_byte(i);
      end
      send_region(bytes_q);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int batch_start;
      int mid;
      int unsigned len;
      logic [wbps_pkg::CSR_DATA_W-1:0] low;
      logic [wbps_pkg::CSR_DATA_W-1:0] high;
      logic [wbps_pkg::CARE_W-1:0] care;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part, reset defaults: signature 00, length 1 ---------
      send_region('{8'hFF, 8'h00});          // match on the last byte
      send_region('{8'hFF});                 // one-byte region, not found

      // A ? B with the middle byte a wildcard
      quiesce();
      set_search(64'h0000_0000_0042_0041, '1, 16'h0005, 5'd3);
      send_region('{8'h41, 8'h41, 8'h5A, 8'h42});   // overlapping start, final start
      send_region('{8'h41, 8'h42});                 // region shorter than signature
      send_region('{8'h41, 8'h00, 8'h42, 8'h42});   // nothing after the first match

      // register change mid-region: care narrows to byte 0 only
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b0);
      quiesce();
      write_reg(wbps_pkg::CSR_CARE_MASK, wbps_pkg::CSR_DATA_W'(16'h0001));
      @(negedge clock);
      csr_valid <= 1'b0;
      send_byte(8'h43, 1'b1);

      // length zero behaves as one
      quiesce();
      set_search(64'h77, '0, 16'hFFFF, 5'd0);
      send_region('{8'h77});
      send_region('{8'h78});

      // --- random part, in three idling profiles ---------------------------
      for (int b = 0; b < BATCHES; b++) begin
         quiesce();
         if (b < 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 69;
         end else if (b < 6) begin
            send_idle_pct = 69;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         low  = {$urandom, $urandom};
         high = {$urandom, $urandom};
         care = wbps_pkg::CARE_W'($urandom);
         len  = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 31);
         case (b)
            0: begin care = '1; len = 16; end          // exact, full width
            1: begin care = '0; len = 31; end          // all wildcards, clamped
            2: len = 0;
            3: begin low = '1; high = '1; end
            4: begin low = '0; high = '0; care = '1; len = 1; end
            default: ;
         endcase
         set_search(low, high, care, wbps_pkg::LEN_CFG_W'(len));

         // receiver holds off while the sender keeps pushing
         if (b == 4) hold_left = 150;

         batch_start = sent_count;
         mid = (b == 7) ? BATCH_BEATS / 2 : BATCH_BEATS;
         while (sent_count - batch_start < mid) send_random_region();
         if (b == 7) quiesce();          // sender waits for every result
         while (sent_count - batch_start < BATCH_BEATS) send_random_region();
      end

      quiesce();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_search.sv
tb/tb_wildcard_byte_pattern_search.sv
